@@ rtl/pidlp_pkg.sv @@
// Shared types, register codes and saturation helpers for the PID loop block.
// Used by pidlp_csr, pidlp_ctrl, pidlp_dp and pid_loop_with_delayed_plant.
`default_nettype none

package pidlp_pkg;

   localparam int CSR_INDEX_W = 3;

   typedef enum logic [CSR_INDEX_W-1:0] {
      CSR_GAIN_PROP     = 3'd0,
      CSR_GAIN_INTEGRAL = 3'd1,
      CSR_GAIN_DERIV    = 3'd2,
      CSR_STEP_SIZE     = 3'd3,
      CSR_STEP_OVER_TC  = 3'd4,
      CSR_PLANT_GAIN    = 3'd5,
      CSR_DELAY_TICKS   = 3'd6
   } csr_index_type;

   localparam logic [30:0] STEP_SIZE_RESET = 31'd65536;

   typedef struct packed {
      logic signed [31:0] gain_prop;
      logic signed [31:0] gain_integral;
      logic signed [31:0] gain_deriv_per_step;
      logic [30:0]        step_size;
      logic [30:0]        step_over_time_const;
      logic signed [31:0] plant_gain;
      logic [7:0]         delay_ticks;
   } cfg_type;

   // One bit per sequencer step; at most one is high in any cycle.
   typedef struct packed {
      logic load_in;
      logic calc_err;
      logic mul_edt;
      logic mul_kp;
      logic mul_ki;
      logic mul_kd;
      logic calc_ctrl;
      logic mul_ku;
      logic calc_diff;
      logic mul_dt;
      logic finish;
   } cmd_type;

   localparam logic signed [63:0] S32_MAX = 64'sd2147483647;
   localparam logic signed [63:0] S32_MIN = -64'sd2147483648;

   function automatic logic signed [31:0] sat32(input logic signed [63:0] v);
      logic signed [31:0] r;
      if (v > S32_MAX) begin
         r = 32'sh7fff_ffff;
      end else if (v < S32_MIN) begin
         r = 32'sh8000_0000;
      end else begin
         r = v[31:0];
      end
      return r;
   endfunction

   function automatic logic signed [31:0] clamp_sym(input logic signed [63:0] v,
                                                   input logic signed [31:0] lim);
      logic signed [31:0] r;
      if (v > 64'(lim)) begin
         r = lim;
      end else if (v < -64'(lim)) begin
         r = -lim;
      end else begin
         r = v[31:0];
      end
      return r;
   endfunction

endpackage

`default_nettype wire

@@ rtl/pid_loop_with_delayed_plant.sv @@
// Top level of the closed-loop PID / dead-time plant tick engine.
// Instantiates pidlp_csr, pidlp_ctrl and pidlp_dp; types from pidlp_pkg.
//
// Usage:
//   Each item on the req_ channel is one simulation tick. req_tdata[0] is the
//   restart flag (clears plant, integral, previous error, line pointer and
//   tick count before the tick); req_tlast marks the last tick of a run and
//   comes back on rsp_tlast. Each tick yields exactly one result item on rsp_.
//   Registers are written on the csr_ channel (index 0..6, others ignored),
//   always ready; write them only while no tick is in flight.
// Sequencing:
//   An accepted item walks the steps ERR, EDT, KP, KI, KD, CTRL, KU, DIFF, DT
//   and FINISH; rsp_tvalid is raised from FINISH once the output register is
//   free. A new item is taken only once the sequencer is back in idle. The steps
//   follow from the single shared 32x32 multiplier, which six products use in turn.
// Stalls:
//   A finished result waits in the output register; the next item is still
//   accepted and computed, and holds in its final step until that register
//   is taken. No item is lost or repeated.
// Reset:
//   Synchronous, active high: clears loop state and registers to their reset
//   values; the dead-time memory is not cleared and needs no clearing pass.
`default_nettype none

module pid_loop_with_delayed_plant #(
   parameter int DELAY_DEPTH = 256,
   parameter int FRAC_BITS   = 16
) (
   input  wire logic                              clock,
   input  wire logic                              reset,
   input  wire logic                              req_tvalid,
   output logic                                   req_tready,
   input  wire logic [7:0]                        req_tdata,  // [0] restart, [7:1] zero
   input  wire logic                              req_tlast,  // final_tick
   output logic                                   rsp_tvalid,
   input  wire logic                              rsp_tready,
   // [31:0] plant_output, [55:32] control_value, [71:56] tick_index
   output logic [71:0]                            rsp_tdata,
   output logic                                   rsp_tlast,  // run_last
   input  wire logic                              csr_valid,
   output logic                                   csr_ready,
   input  wire logic [pidlp_pkg::CSR_INDEX_W-1:0] csr_index,
   input  wire logic [31:0]                       csr_wdata
);
   import pidlp_pkg::*;

   cfg_type            cfg;
   cmd_type            cmd;
   logic signed [31:0] plant_output;
   logic signed [23:0] control_value;
   logic [15:0]        tick_index;

   pidlp_csr u_csr (
      .clock     (clock),
      .reset     (reset),
      .csr_valid (csr_valid),
      .csr_ready (csr_ready),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata),
      .cfg       (cfg)
   );

   pidlp_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .cmd        (cmd)
   );

   pidlp_dp #(
      .DELAY_DEPTH (DELAY_DEPTH),
      .FRAC_BITS   (FRAC_BITS)
   ) u_dp (
      .clock         (clock),
      .reset         (reset),
      .cmd           (cmd),
      .cfg           (cfg),
      .in_restart    (req_tdata[0]),
      .in_last       (req_tlast),
      .plant_output  (plant_output),
      .control_value (control_value),
      .tick_index    (tick_index),
      .run_last      (rsp_tlast)
   );

   assign rsp_tdata = {tick_index, control_value, plant_output};

endmodule

`default_nettype wire

@@ rtl/pidlp_csr.sv @@
// Configuration register file for the PID loop block.
// Depends on pidlp_pkg for the register codes and the cfg_type bundle.
`default_nettype none

module pidlp_csr (
   input  wire logic                                   clock,
   input  wire logic                                   reset,
   input  wire logic                                   csr_valid,
   output logic                                        csr_ready,
   input  wire logic [pidlp_pkg::CSR_INDEX_W-1:0]      csr_index,
   input  wire logic [31:0]                            csr_wdata,
   output pidlp_pkg::cfg_type                          cfg
);
   import pidlp_pkg::*;

   cfg_type cfg_ff;
   cfg_type cfg_in;

   assign csr_ready = 1'b1;
   assign cfg = cfg_ff;

   always_comb begin
      cfg_in = cfg_ff;
      if (csr_valid) begin
         unique case (csr_index)
            CSR_GAIN_PROP:     cfg_in.gain_prop            = csr_wdata;
            CSR_GAIN_INTEGRAL: cfg_in.gain_integral        = csr_wdata;
            CSR_GAIN_DERIV:    cfg_in.gain_deriv_per_step  = csr_wdata;
            CSR_STEP_SIZE:     cfg_in.step_size            = csr_wdata[30:0];
            CSR_STEP_OVER_TC:  cfg_in.step_over_time_const = csr_wdata[30:0];
            CSR_PLANT_GAIN:    cfg_in.plant_gain           = csr_wdata;
            CSR_DELAY_TICKS:   cfg_in.delay_ticks          = csr_wdata[7:0];
            default:           cfg_in = cfg_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.gain_prop            <= '0;
         cfg_ff.gain_integral        <= '0;
         cfg_ff.gain_deriv_per_step  <= '0;
         cfg_ff.step_size            <= STEP_SIZE_RESET;
         cfg_ff.step_over_time_const <= '0;
         cfg_ff.plant_gain           <= '0;
         cfg_ff.delay_ticks          <= '0;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

endmodule

`default_nettype wire

@@ rtl/pidlp_ctrl.sv @@
// Sequencer for one loop tick: walks the shared multiplier through its steps.
// Depends on pidlp_pkg for cmd_type; drives pidlp_dp through cmd.
`default_nettype none

module pidlp_ctrl (
   input  wire logic          clock,
   input  wire logic          reset,
   input  wire logic          req_tvalid,
   output logic               req_tready,
   output logic               rsp_tvalid,
   input  wire logic          rsp_tready,
   output pidlp_pkg::cmd_type cmd
);
   import pidlp_pkg::*;

   typedef enum logic [10:0] {
      ST_IDLE   = 11'b000_0000_0001,
      ST_ERR    = 11'b000_0000_0010,
      ST_EDT    = 11'b000_0000_0100,
      ST_KP     = 11'b000_0000_1000,
      ST_KI     = 11'b000_0001_0000,
      ST_KD     = 11'b000_0010_0000,
      ST_CTRL   = 11'b000_0100_0000,
      ST_KU     = 11'b000_1000_0000,
      ST_DIFF   = 11'b001_0000_0000,
      ST_DT     = 11'b010_0000_0000,
      ST_FINISH = 11'b100_0000_0000
   } state_type;

   state_type state_ff, state_in;
   logic      rsp_valid_ff, rsp_valid_in;
   logic      slot_free;

   assign req_tready = (state_ff == ST_IDLE);
   assign rsp_tvalid = rsp_valid_ff;
   assign slot_free  = !rsp_valid_ff || rsp_tready;

   always_comb begin
      state_in     = state_ff;
      rsp_valid_in = rsp_valid_ff;
      cmd          = '0;
      if (rsp_tready) begin
         rsp_valid_in = 1'b0;
      end
      unique case (state_ff)
         ST_IDLE: begin
            if (req_tvalid) begin
               cmd.load_in = 1'b1;
               state_in    = ST_ERR;
            end
         end
         ST_ERR: begin
            cmd.calc_err = 1'b1;
            state_in     = ST_EDT;
         end
         ST_EDT: begin
            cmd.mul_edt = 1'b1;
            state_in    = ST_KP;
         end
         ST_KP: begin
            cmd.mul_kp = 1'b1;
            state_in   = ST_KI;
         end
         ST_KI: begin
            cmd.mul_ki = 1'b1;
            state_in   = ST_KD;
         end
         ST_KD: begin
            cmd.mul_kd = 1'b1;
            state_in   = ST_CTRL;
         end
         ST_CTRL: begin
            cmd.calc_ctrl = 1'b1;
            state_in      = ST_KU;
         end
         ST_KU: begin
            cmd.mul_ku = 1'b1;
            state_in   = ST_DIFF;
         end
         ST_DIFF: begin
            cmd.calc_diff = 1'b1;
            state_in      = ST_DT;
         end
         ST_DT: begin
            cmd.mul_dt = 1'b1;
            state_in   = ST_FINISH;
         end
         ST_FINISH: begin
            // hold the plant update until the output register can take the item
            if (slot_free) begin
               cmd.finish   = 1'b1;
               rsp_valid_in = 1'b1;
               state_in     = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

`ifndef SYNTH
   a_accept_starts_tick: assert property (@(posedge clock) disable iff (reset)
      (req_tvalid && req_tready) |=> (state_ff == ST_ERR))
      else $error("accepted item did not start a tick");

   a_rsp_from_finish: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_tvalid) |-> $past(state_ff == ST_FINISH))
      else $error("result raised outside the finish step");

   a_no_overwrite: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_FINISH && rsp_valid_ff && !rsp_tready) |=> (state_ff == ST_FINISH))
      else $error("finish step passed while the output register was full");

   a_mul_chain: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_DT) |=> (state_ff == ST_FINISH))
      else $error("plant multiply not followed by the finish step");
`endif

endmodule

`default_nettype wire

@@ rtl/pidlp_dp.sv @@
// Datapath of the PID loop: loop state, shared 32x32 multiplier, dead-time memory.
// Depends on pidlp_pkg for cfg_type, cmd_type and the saturation helpers.
`default_nettype none

module pidlp_dp #(
   parameter int DELAY_DEPTH = 256,
   parameter int FRAC_BITS   = 16
) (
   input  wire logic               clock,
   input  wire logic               reset,
   input  wire pidlp_pkg::cmd_type cmd,
   input  wire pidlp_pkg::cfg_type cfg,
   input  wire logic               in_restart,
   input  wire logic               in_last,
   output logic signed [31:0]      plant_output,
   output logic signed [23:0]      control_value,
   output logic [15:0]             tick_index,
   output logic                    run_last
);
   import pidlp_pkg::*;

   localparam int PW = $clog2(DELAY_DEPTH > 1 ? DELAY_DEPTH : 2);
   localparam int unsigned DMAX = DELAY_DEPTH - 1;
   localparam logic [PW:0] DEPTH_W = (PW + 1)'(DELAY_DEPTH);
   localparam logic signed [31:0] FX_ONE    = 32'(64'sd1 << FRAC_BITS);
   localparam logic signed [31:0] INTEG_LIM = 32'(64'sd10 << FRAC_BITS);
   localparam logic signed [31:0] CTRL_LIM  = 32'(64'sd100 << FRAC_BITS);

   logic signed [31:0] y_ff, integ_ff, prev_ff;
   logic [PW-1:0]      ptr_ff;
   logic [15:0]        tick_ff;
   logic               restart_ff, last_ff;
   logic signed [31:0] e_ff, de_ff, u_ff, ud_ff, diff_ff, rdata_ff;
   logic signed [33:0] acc_ff;
   logic signed [63:0] prod_ff;
   logic signed [31:0] dline_ff [DELAY_DEPTH];
   logic signed [31:0] out_y_ff;
   logic signed [23:0] out_u_ff;
   logic [15:0]        out_idx_ff;
   logic               out_last_ff;

   logic signed [31:0] fx, y_eff, prev_eff, e_in, de_in, integ_in, dterm;
   logic signed [31:0] u_in, diff_in, y_in, mul_a, mul_b;
   logic signed [63:0] prod_in;
   logic [PW-1:0]      d_eff, rd_addr, ptr_in;
   logic [PW:0]        rd_wrap;
   logic               line_empty;
   logic               mul_any;

   always_comb begin
      fx       = sat32(prod_ff >>> FRAC_BITS);
      y_eff    = restart_ff ? '0 : y_ff;
      prev_eff = restart_ff ? '0 : prev_ff;
      e_in     = sat32(64'(FX_ONE) - 64'(y_eff));
      de_in    = sat32(64'(e_in) - 64'(prev_eff));
      integ_in = clamp_sym(64'(integ_ff) + 64'(fx), INTEG_LIM);
      dterm    = (tick_ff != '0) ? fx : '0;
      u_in     = clamp_sym(64'(sat32(64'(acc_ff) + 64'(dterm))), CTRL_LIM);
      diff_in  = sat32(64'(fx) - 64'(y_ff));
      y_in     = sat32(64'(y_ff) + 64'(fx));

      // dead time saturates at the last line entry
      d_eff      = (32'(cfg.delay_ticks) > DMAX) ? PW'(DMAX) : PW'(cfg.delay_ticks);
      line_empty = (32'(tick_ff) < 32'(d_eff));
      rd_wrap    = (PW + 1)'(ptr_ff) + DEPTH_W - (PW + 1)'(d_eff);
      rd_addr    = (ptr_ff >= d_eff) ? ptr_ff - d_eff : rd_wrap[PW-1:0];
      ptr_in     = (32'(ptr_ff) + 32'd1 >= 32'(DELAY_DEPTH)) ? '0 : ptr_ff + 1'b1;

      mul_any = cmd.mul_edt || cmd.mul_kp || cmd.mul_ki || cmd.mul_kd ||
                cmd.mul_ku || cmd.mul_dt;
      mul_a = '0;
      mul_b = '0;
      priority if (cmd.mul_edt) begin
         mul_a = e_ff;
         mul_b = $signed({1'b0, cfg.step_size});
      end else if (cmd.mul_kp) begin
         mul_a = cfg.gain_prop;
         mul_b = e_ff;
      end else if (cmd.mul_ki) begin
         mul_a = cfg.gain_integral;
         mul_b = integ_ff;
      end else if (cmd.mul_kd) begin
         mul_a = cfg.gain_deriv_per_step;
         mul_b = de_ff;
      end else if (cmd.mul_ku) begin
         mul_a = cfg.plant_gain;
         mul_b = ud_ff;
      end else if (cmd.mul_dt) begin
         mul_a = diff_ff;
         mul_b = $signed({1'b0, cfg.step_over_time_const});
      end
      prod_in = 64'(mul_a) * 64'(mul_b);
   end

   // loop state
   always_ff @(posedge clock) begin
      if (reset) begin
         y_ff     <= '0;
         integ_ff <= '0;
         prev_ff  <= '0;
         ptr_ff   <= '0;
         tick_ff  <= '0;
      end else begin
         if (cmd.calc_err && restart_ff) begin
            y_ff     <= '0;
            integ_ff <= '0;
            prev_ff  <= '0;
            ptr_ff   <= '0;
            tick_ff  <= '0;
         end
         if (cmd.mul_kp) begin
            integ_ff <= integ_in;
         end
         if (cmd.finish) begin
            y_ff    <= y_in;
            prev_ff <= e_ff;
            ptr_ff  <= ptr_in;
            if (tick_ff != 16'hffff) begin
               tick_ff <= tick_ff + 16'd1;
            end
         end
      end
   end

   // working registers
   always_ff @(posedge clock) begin
      // hold the last product while the finish step waits
      if (mul_any) begin
         prod_ff <= prod_in;
      end
      if (cmd.load_in) begin
         restart_ff <= in_restart;
         last_ff    <= in_last;
      end
      if (cmd.calc_err) begin
         e_ff  <= e_in;
         de_ff <= de_in;
      end
      if (cmd.mul_ki) begin
         acc_ff <= 34'(fx);
      end
      if (cmd.mul_kd) begin
         acc_ff <= acc_ff + 34'(fx);
      end
      if (cmd.calc_ctrl) begin
         u_ff <= u_in;
         if (line_empty) begin
            ud_ff <= '0;
         end else if (d_eff == '0) begin
            ud_ff <= u_in;
         end else begin
            ud_ff <= rdata_ff;
         end
      end
      if (cmd.calc_diff) begin
         diff_ff <= diff_in;
      end
      if (cmd.finish) begin
         out_y_ff    <= y_in;
         out_u_ff    <= u_ff[23:0];
         out_idx_ff  <= tick_ff;
         out_last_ff <= last_ff;
      end
   end

   // dead-time line: read ahead of the write, which lands at the current pointer
   always_ff @(posedge clock) begin
      if (cmd.mul_ki) begin
         rdata_ff <= dline_ff[rd_addr];
      end
      if (cmd.calc_ctrl) begin
         dline_ff[ptr_ff] <= u_in;
      end
   end

   assign plant_output  = out_y_ff;
   assign control_value = out_u_ff;
   assign tick_index    = out_idx_ff;
   assign run_last      = out_last_ff;

endmodule

`default_nettype wire

@@ tb/sv/tb_pid_loop_with_delayed_plant.sv @@
// Self-checking bench for pid_loop_with_delayed_plant: a scoreboard class predicts every
// tick of the PID loop and dead-time plant and checks each result item field by field.
// Depends on pidlp_pkg (register codes, cfg_type) and the top-level RTL.
module tb_pid_loop_with_delayed_plant;
   timeunit 1ns;
   timeprecision 1ps;

   import pidlp_pkg::*;

   localparam int     LINE_DEPTH     = 256;
   localparam int     FRAC           = 16;
   localparam longint UNITY          = 64'sd65536;
   localparam longint INTEG_MAX      = 10 * UNITY;
   localparam longint CTRL_MAX       = 100 * UNITY;
   localparam longint I32_MAX        = 64'sd2147483647;
   localparam longint I32_MIN        = -64'sd2147483648;
   localparam int     TICK_SAT       = 65535;
   localparam int     LONG_RUN_TICKS = 280;
   localparam int     RANDOM_PHASES  = 11;
   localparam int     PHASE_TICKS    = 80;
   localparam int     TIMEOUT_CYCLES = 3_000_000;
   localparam logic [CSR_INDEX_W-1:0] CSR_NOT_MAPPED = 3'd7;

   typedef struct packed {
      logic signed [31:0] plant_output;
      logic signed [23:0] control_value;
      logic [15:0]        tick_index;
      logic               run_last;
   } tick_result_type;

   class loop_tracker_type;
      cfg_type            cfg;
      longint             plant_y;
      longint             err_sum;
      longint             last_err;
      logic signed [31:0] dead_line [LINE_DEPTH];
      int unsigned        line_ptr;
      int unsigned        tick_cnt;
      tick_result_type    expected_q[$];
      int unsigned        mismatches;
      int unsigned        checked;
      int unsigned        top_index;

      function new();
         cfg = '0;
         cfg.step_size = STEP_SIZE_RESET;
         foreach (dead_line[i]) dead_line[i] = '0;
         restart_loop();
         mismatches = 0;
         checked    = 0;
         top_index  = 0;
      endfunction

      static function longint lim(longint v, longint lo, longint hi);
         return (v < lo) ? lo : ((v > hi) ? hi : v);
      endfunction

      // Product floored by 2^FRAC, then saturated to 32 bits.
      static function longint fx_mul(longint a, longint b);
         return lim((a * b) >>> FRAC, I32_MIN, I32_MAX);
      endfunction

      function void restart_loop();
         plant_y  = 0;
         err_sum  = 0;
         last_err = 0;
         line_ptr = 0;
         tick_cnt = 0;
      endfunction

      function void set_reg(logic [CSR_INDEX_W-1:0] idx, logic [31:0] val);
         case (idx)
            CSR_GAIN_PROP:     cfg.gain_prop = val;
            CSR_GAIN_INTEGRAL: cfg.gain_integral = val;
            CSR_GAIN_DERIV:    cfg.gain_deriv_per_step = val;
            CSR_STEP_SIZE:     cfg.step_size = val[30:0];
            CSR_STEP_OVER_TC:  cfg.step_over_time_const = val[30:0];
            CSR_PLANT_GAIN:    cfg.plant_gain = val;
            CSR_DELAY_TICKS:   cfg.delay_ticks = val[7:0];
            default: ;
         endcase
      endfunction

      function void take_tick(bit restart, bit last);
         tick_result_type r;
         longint       err;
         longint       deriv;
         longint       ctrl;
         longint       delayed;
         longint       target;
         longint       diff;
         int unsigned  lag;
         if (restart) restart_loop();
         r.tick_index = tick_cnt[15:0];
         r.run_last   = last;
         if (tick_cnt > top_index) top_index = tick_cnt;

         err = lim(UNITY - plant_y, I32_MIN, I32_MAX);
         err_sum = lim(err_sum + fx_mul(err, longint'({1'b0, cfg.step_size})),
                       -INTEG_MAX, INTEG_MAX);
         deriv = 0;
         if (tick_cnt != 0)
            deriv = fx_mul(longint'($signed(cfg.gain_deriv_per_step)),
                           lim(err - last_err, I32_MIN, I32_MAX));
         ctrl = fx_mul(longint'($signed(cfg.gain_prop)), err)
              + fx_mul(longint'($signed(cfg.gain_integral)), err_sum) + deriv;
         ctrl = lim(lim(ctrl, I32_MIN, I32_MAX), -CTRL_MAX, CTRL_MAX);

         dead_line[line_ptr] = ctrl[31:0];
         lag = 32'(cfg.delay_ticks);
         if (lag > LINE_DEPTH - 1) lag = LINE_DEPTH - 1;
         // Line reads zero until it holds lag earlier ticks of this run.
         if (tick_cnt < lag) begin
            delayed = 0;
         end else begin
            delayed = longint'(dead_line[(line_ptr + LINE_DEPTH - lag) % LINE_DEPTH]);
         end
         line_ptr = (line_ptr + 1) % LINE_DEPTH;

         target  = fx_mul(longint'($signed(cfg.plant_gain)), delayed);
         diff    = lim(target - plant_y, I32_MIN, I32_MAX);
         plant_y = lim(plant_y + fx_mul(diff, longint'({1'b0, cfg.step_over_time_const})),
                       I32_MIN, I32_MAX);

         r.plant_output  = plant_y[31:0];
         r.control_value = ctrl[23:0];
         last_err = err;
         if (tick_cnt < TICK_SAT) tick_cnt++;
         expected_q.push_back(r);
      endfunction

      function void check_tick(logic [71:0] data, logic last);
         tick_result_type want;
         checked++;
         if (expected_q.size() == 0) begin
            $error("result item with no tick pending: plant_output %0d",
                   $signed(data[31:0]));
            mismatches++;
            return;
         end
         want = expected_q.pop_front();
         if (data[31:0] !== want.plant_output) begin
            $error("plant_output: expected %0d, actual %0d",
                   want.plant_output, $signed(data[31:0]));
            mismatches++;
         end
         if (data[55:32] !== want.control_value) begin
            $error("control_value: expected %0d, actual %0d",
                   want.control_value, $signed(data[55:32]));
            mismatches++;
         end
         if (data[71:56] !== want.tick_index) begin
            $error("tick_index: expected %0d, actual %0d", want.tick_index, data[71:56]);
            mismatches++;
         end
         if (last !== want.run_last) begin
            $error("run_last: expected %0d, actual %0d", want.run_last, last);
            mismatches++;
         end
      endfunction
   endclass

   logic                   clock;
   logic                   reset;
   logic                   req_tvalid;
   logic                   req_tready;
   logic [7:0]             req_tdata;
   logic                   req_tlast;
   logic                   rsp_tvalid;
   logic                   rsp_tready;
   logic [71:0]            rsp_tdata;
   logic                   rsp_tlast;
   logic                   csr_valid;
   logic                   csr_ready;
   logic [CSR_INDEX_W-1:0] csr_index;
   logic [31:0]            csr_wdata;

   loop_tracker_type tracker = new();
   bit          idle_on;
   int unsigned cycle_count;
   int unsigned settings_loaded;

   pid_loop_with_delayed_plant #(
      .DELAY_DEPTH(LINE_DEPTH),
      .FRAC_BITS  (FRAC)
   ) u_dut (
      .clock     (clock),
      .reset     (reset),
      .req_tvalid(req_tvalid),
      .req_tready(req_tready),
      .req_tdata (req_tdata),
      .req_tlast (req_tlast),
      .rsp_tvalid(rsp_tvalid),
      .rsp_tready(rsp_tready),
      .rsp_tdata (rsp_tdata),
      .rsp_tlast (rsp_tlast),
      .csr_valid (csr_valid),
      .csr_ready (csr_ready),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata)
   );

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   always @(posedge clock) cycle_count <= cycle_count + 1;

   initial begin
      wait (cycle_count >= TIMEOUT_CYCLES);
      $display("[pid_loop_with_delayed_plant] ERROR");
      $finish;
   end

   // Result side: check what was taken at this edge, then pick the next ready.
   initial begin
      rsp_tready = 1'b0;
      forever begin
         @(posedge clock);
         if (!reset && rsp_tvalid && rsp_tready) tracker.check_tick(rsp_tdata, rsp_tlast);
         rsp_tready <= idle_on ? ($urandom_range(0, 99) >= 20) : 1'b1;
      end
   end

   task automatic send_tick(bit restart, bit last);
      if (idle_on && $urandom_range(0, 99) < 20) begin
         req_tvalid <= 1'b0;
         repeat ($urandom_range(1, 14)) @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata  <= {7'd0, restart};
      req_tlast  <= last;
      do @(posedge clock); while (!req_tready);
      tracker.take_tick(restart, last);
   endtask

   // Hold the sender until every pending tick has come back.
   task automatic drain();
      req_tvalid <= 1'b0;
      while (tracker.expected_q.size() != 0) @(posedge clock);
      repeat (12) @(posedge clock);
   endtask

   task automatic write_reg(logic [CSR_INDEX_W-1:0] idx, logic [31:0] val);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_wdata <= val;
      do @(posedge clock); while (!csr_ready);
      tracker.set_reg(idx, val);
   endtask

   task automatic load_settings(cfg_type c);
      drain();
      write_reg(CSR_NOT_MAPPED, $urandom());
      write_reg(CSR_GAIN_PROP, c.gain_prop);
      write_reg(CSR_GAIN_INTEGRAL, c.gain_integral);
      write_reg(CSR_GAIN_DERIV, c.gain_deriv_per_step);
      write_reg(CSR_STEP_SIZE, {1'b0, c.step_size});
      write_reg(CSR_STEP_OVER_TC, {1'b0, c.step_over_time_const});
      write_reg(CSR_PLANT_GAIN, c.plant_gain);
      write_reg(CSR_DELAY_TICKS, {24'd0, c.delay_ticks});
      csr_valid <= 1'b0;
      settings_loaded++;
   endtask

   function automatic cfg_type settings_of(logic [31:0] kp, logic [31:0] ki,
                                           logic [31:0] kd, logic [30:0] dt,
                                           logic [30:0] dtc, logic [31:0] k,
                                           logic [7:0] delay);
      cfg_type c;
      c.gain_prop            = kp;
      c.gain_integral        = ki;
      c.gain_deriv_per_step  = kd;
      c.step_size            = dt;
      c.step_over_time_const = dtc;
      c.plant_gain           = k;
      c.delay_ticks          = delay;
      return c;
   endfunction

   function automatic logic [31:0] pick_s32();
      case ($urandom_range(0, 4))
         0: return 32'h8000_0000;
         1: return 32'h7fff_ffff;
         2: return 32'd0;
         default: return $urandom();
      endcase
   endfunction

   function automatic logic [30:0] pick_u31();
      logic [31:0] r;
      r = $urandom();
      case ($urandom_range(0, 4))
         0: return 31'd0;
         1: return 31'h7fff_ffff;
         2: return 31'd1;
         default: return r[30:0];
      endcase
   endfunction

   // Loops that settle or ring: moderate gains, modest steps, short dead time mostly.
   function automatic cfg_type tame_settings();
      logic signed [31:0] kp;
      logic [7:0]         delay;
      kp = $urandom_range(0, 4 * 65536);
      if ($urandom_range(0, 9) == 0) kp = -kp;
      delay = 8'(($urandom_range(0, 9) < 7) ? $urandom_range(0, 6) : $urandom_range(0, 255));
      return settings_of(kp, $urandom_range(0, 2 * 65536), $urandom_range(0, 65536),
                         31'($urandom_range(4096, 65536)), 31'($urandom_range(2048, 32768)),
                         $urandom_range(32768, 3 * 65536), delay);
   endfunction

   function automatic cfg_type wild_settings();
      logic [7:0] delay;
      case ($urandom_range(0, 2))
         0: delay = 8'd0;
         1: delay = 8'd255;
         default: delay = 8'($urandom_range(0, 255));
      endcase
      return settings_of(pick_s32(), pick_s32(), pick_s32(), pick_u31(), pick_u31(),
                         pick_s32(), delay);
   endfunction

   initial begin
      int unsigned sent;
      int unsigned len;
      reset      = 1'b1;
      req_tvalid = 1'b0;
      req_tdata  = '0;
      req_tlast  = 1'b0;
      csr_valid  = 1'b0;
      csr_index  = '0;
      csr_wdata  = '0;
      idle_on    = 1'b1;
      settings_loaded = 0;
      repeat (4) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // Registers at their reset values, no restart: first tick has no derivative.
      send_tick(1'b0, 1'b0);
      send_tick(1'b0, 1'b1);

      // Nominal loop with a short dead time, restarted mid-run.
      load_settings(settings_of(32'd65536, 32'd32768, 32'd16384, 31'd32768, 31'd32768,
                                32'd65536, 8'd3));
      for (int k = 0; k < 8; k++) send_tick(k == 0 || k == 5, k == 7);

      // Every gain at its maximum, largest step, no dead time.
      load_settings(settings_of(32'h7fff_ffff, 32'h7fff_ffff, 32'h7fff_ffff, 31'h7fff_ffff,
                                31'h7fff_ffff, 32'h7fff_ffff, 8'd0));
      for (int k = 0; k < 4; k++) send_tick(k == 0, k == 3);

      // Most negative gains, zero step, longest dead time.
      load_settings(settings_of(32'h8000_0000, 32'h8000_0000, 32'h8000_0000, 31'd0,
                                31'h7fff_ffff, 32'h8000_0000, 8'd255));
      for (int k = 0; k < 4; k++) send_tick(k == 0, 1'b0);
      send_tick(1'b1, 1'b1);

      // Drive the plant to the negative rail so the error and its difference saturate.
      load_settings(settings_of(32'h8000_0000, 32'd0, 32'h7fff_ffff, 31'd1, 31'h7fff_ffff,
                                32'h7fff_ffff, 8'd1));
      for (int k = 0; k < 5; k++) send_tick(k == 0, k == 4);

      for (int phase = 0; phase < RANDOM_PHASES; phase++) begin
         idle_on = (phase != 5);
         load_settings(($urandom_range(0, 99) < 65) ? tame_settings() : wild_settings());
         sent = 0;
         while (sent < PHASE_TICKS) begin
            if ($urandom_range(0, 9) == 0) begin
               send_tick(1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)));
               sent++;
            end else begin
               // Runs of random length; one in four is long enough to see the dead-time line deliver.
               if ($urandom_range(0, 3) == 0) begin
                  len = tracker.cfg.delay_ticks + $urandom_range(1, 60);
               end else begin
                  len = $urandom_range(1, 40);
               end
               for (int k = 0; k < len; k++)
                  send_tick(k == 0 && $urandom_range(0, 19) != 0, k == len - 1);
               sent += len;
            end
            if ($urandom_range(0, 19) == 0) drain();
         end
      end

      // One long run that wraps the line at the longest dead time.
      idle_on = 1'b0;
      load_settings(settings_of(32'd98304, 32'd6554, 32'd3277, 31'd6554, 31'd3277,
                                32'd65536, 8'd255));
      for (int k = 0; k < LONG_RUN_TICKS; k++) send_tick(k == 0, k == LONG_RUN_TICKS - 1);

      idle_on = 1'b1;
      drain();
      repeat (20) @(posedge clock);
      $display("Run covered %0d ticks under %0d register settings, from tame loops to",
               tracker.checked, settings_loaded);
      $display("saturated extremes, restarts and tick indexes up to %0d.", tracker.top_index);
      if (tracker.mismatches == 0 && tracker.expected_q.size() == 0) begin
         $display("[pid_loop_with_delayed_plant] OK");
      end else begin
         $display("[pid_loop_with_delayed_plant] ERROR");
      end
      $finish;
   end

endmodule

@@ files.f @@
rtl/pidlp_pkg.sv
rtl/pidlp_csr.sv
rtl/pidlp_ctrl.sv
rtl/pidlp_dp.sv
rtl/pid_loop_with_delayed_plant.sv
tb/sv/tb_pid_loop_with_delayed_plant.sv
